### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define KDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

### rtl/core/kdc_pkg.sv
// Types, codes and reset constants of the key debounce click classifier.
package kdc_pkg;

	localparam int REG_W    = 16;
	localparam int FLAG_W   = 7;
	localparam int CFG_IDX_W = 4;

	// Operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_CHECK = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 4'd3;

	// Register reset values
	localparam logic [REG_W-1:0] RST_DEBOUNCE = 16'd20;
	localparam logic [REG_W-1:0] RST_DOUBLE   = 16'd200;
	localparam logic [REG_W-1:0] RST_LONG     = 16'd2000;
	localparam logic [REG_W-1:0] RST_REPEAT   = 16'd100;

	// Click mode codes
	localparam logic [2:0] MODE_WAIT      = 3'd0;
	localparam logic [2:0] MODE_WAIT_LONG = 3'd1;
	localparam logic [2:0] MODE_WAIT_DBL  = 3'd2;
	localparam logic [2:0] MODE_DBL_DONE  = 3'd3;
	localparam logic [2:0] MODE_REPEAT    = 3'd4;

	// Flag bit positions
	localparam int FLAG_HOLD   = 0;
	localparam int FLAG_DOWN   = 1;
	localparam int FLAG_UP     = 2;
	localparam int FLAG_SINGLE = 3;
	localparam int FLAG_DOUBLE = 4;
	localparam int FLAG_LONG   = 5;
	localparam int FLAG_REPEAT = 6;

	localparam logic [FLAG_W-1:0] FLAGS_HOLD_ONLY = 7'b000_0001;

	typedef struct packed {
		logic [1:0]        operation;
		logic              raw_pressed;
		logic [FLAG_W-1:0] check_mask;
	} item_t;

	typedef struct packed {
		logic              check_hit;
		logic [FLAG_W-1:0] event_flags;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [REG_W-1:0]     data;
	} cfg_beat_t;

	typedef struct packed {
		logic [REG_W-1:0] debounce_ticks;
		logic [REG_W-1:0] double_window_ticks;
		logic [REG_W-1:0] long_press_ticks;
		logic [REG_W-1:0] repeat_ticks;
	} cfg_regs_t;

endpackage

### rtl/core/kdc_stream_if.sv
// Valid/ready channel interface carrying one payload per beat.
interface kdc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/kdc_cfg_regs.sv
// Configuration register file: four 16-bit timing registers.
module kdc_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  kdc_pkg::cfg_beat_t   wr_beat,
	output kdc_pkg::cfg_regs_t   regs
);

	kdc_pkg::cfg_regs_t regs_q;

	// Indexed write; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_ticks      <= kdc_pkg::RST_DEBOUNCE;
			regs_q.double_window_ticks <= kdc_pkg::RST_DOUBLE;
			regs_q.long_press_ticks    <= kdc_pkg::RST_LONG;
			regs_q.repeat_ticks        <= kdc_pkg::RST_REPEAT;
		end else if (wr_en) begin
			case (wr_beat.index)
				kdc_pkg::REG_DEBOUNCE: regs_q.debounce_ticks      <= wr_beat.data;
				kdc_pkg::REG_DOUBLE:   regs_q.double_window_ticks <= wr_beat.data;
				kdc_pkg::REG_LONG:     regs_q.long_press_ticks    <= wr_beat.data;
				kdc_pkg::REG_REPEAT:   regs_q.repeat_ticks        <= wr_beat.data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

### rtl/core/kdc_step.sv
// Next-state logic: debounce, click classification and flag check/clear for one item.
module kdc_step #(
	parameter int COUNT_WIDTH = 16
) (
	input  kdc_pkg::item_t                     item,
	input  kdc_pkg::cfg_regs_t                 regs,
	input  logic                               level_q,
	input  logic [2:0]                         mode_q,
	input  logic [COUNT_WIDTH-1:0]             bounce_q,
	input  logic [COUNT_WIDTH-1:0]             window_q,
	input  logic [kdc_pkg::FLAG_W-1:0]         flags_q,
	output logic                               level_d,
	output logic [2:0]                         mode_d,
	output logic [COUNT_WIDTH-1:0]             bounce_d,
	output logic [COUNT_WIDTH-1:0]             window_d,
	output logic [kdc_pkg::FLAG_W-1:0]         flags_d,
	output kdc_pkg::result_t                   result
);

	localparam int CMP_W = (COUNT_WIDTH > kdc_pkg::REG_W) ? COUNT_WIDTH : kdc_pkg::REG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] bounce_inc;
	logic [COUNT_WIDTH-1:0] window_inc;
	logic                   bounce_done;
	logic                   long_done;
	logic                   dbl_done;
	logic                   rpt_done;
	logic                   hit;

	// Saturating increments and threshold compares
	assign bounce_inc  = (bounce_q == CNT_MAX) ? bounce_q : bounce_q + 1'b1;
	assign window_inc  = (window_q == CNT_MAX) ? window_q : window_q + 1'b1;
	assign bounce_done = CMP_W'(bounce_inc) >= CMP_W'(regs.debounce_ticks);
	assign long_done   = CMP_W'(window_inc) >= CMP_W'(regs.long_press_ticks);
	assign dbl_done    = CMP_W'(window_inc) >= CMP_W'(regs.double_window_ticks);
	assign rpt_done    = CMP_W'(window_inc) >= CMP_W'(regs.repeat_ticks);

	always_comb begin
		level_d  = level_q;
		mode_d   = mode_q;
		bounce_d = bounce_q;
		window_d = window_q;
		flags_d  = flags_q;
		hit      = 1'b0;
		case (item.operation)
			kdc_pkg::OP_TICK: begin
				// debounce run-length counter
				if (item.raw_pressed == level_q) begin
					bounce_d = '0;
				end else begin
					bounce_d = bounce_inc;
					if (bounce_done) begin
						level_d  = item.raw_pressed;
						bounce_d = '0;
						if (item.raw_pressed) begin
							flags_d[kdc_pkg::FLAG_DOWN] = 1'b1;
						end else begin
							flags_d[kdc_pkg::FLAG_UP] = 1'b1;
						end
					end
				end
				flags_d[kdc_pkg::FLAG_HOLD] = level_d;

				// click classifier
				case (mode_q)
					kdc_pkg::MODE_WAIT: begin
						if (level_d) begin
							mode_d   = kdc_pkg::MODE_WAIT_LONG;
							window_d = '0;
						end
					end
					kdc_pkg::MODE_WAIT_LONG: begin
						window_d = window_inc;
						if (!level_d) begin
							mode_d   = kdc_pkg::MODE_WAIT_DBL;
							window_d = '0;
						end else if (long_done) begin
							flags_d[kdc_pkg::FLAG_LONG] = 1'b1;
							mode_d   = kdc_pkg::MODE_REPEAT;
							window_d = '0;
						end
					end
					kdc_pkg::MODE_WAIT_DBL: begin
						window_d = window_inc;
						if (level_d) begin
							flags_d[kdc_pkg::FLAG_DOUBLE] = 1'b1;
							mode_d = kdc_pkg::MODE_DBL_DONE;
						end else if (dbl_done) begin
							flags_d[kdc_pkg::FLAG_SINGLE] = 1'b1;
							mode_d = kdc_pkg::MODE_WAIT;
						end
					end
					kdc_pkg::MODE_DBL_DONE: begin
						if (!level_d) begin
							mode_d = kdc_pkg::MODE_WAIT;
						end
					end
					kdc_pkg::MODE_REPEAT: begin
						window_d = window_inc;
						if (!level_d) begin
							mode_d = kdc_pkg::MODE_WAIT;
						end else if (rpt_done) begin
							flags_d[kdc_pkg::FLAG_REPEAT] = 1'b1;
							window_d = '0;
						end
					end
					default: begin
						mode_d = kdc_pkg::MODE_WAIT;
					end
				endcase
			end
			kdc_pkg::OP_CHECK: begin
				// hit consumes the masked flags unless only hold is set
				if (|(flags_q & item.check_mask)) begin
					hit = 1'b1;
					if (flags_q != kdc_pkg::FLAGS_HOLD_ONLY) begin
						flags_d = flags_q & ~item.check_mask;
					end
				end
			end
			kdc_pkg::OP_CLEAR: begin
				flags_d = '0;
			end
			default: ;
		endcase
	end

	assign result.check_hit   = hit;
	assign result.event_flags = flags_d;

endmodule

### rtl/core/key_debounce_click_classifier_core.sv
// An accepted item beat goes through the item and result registers.
// Throughput: one item per cycle, sustained while result beats are taken;
// the per-item state update is one combinational pass between the item
// register and the result register. Config writes are registered.
// Reset (arst_n low): released level, waiting mode, counters and flags zero,
// timing registers at 20/200/2000/100 ticks, both pipeline stages empty.
module key_debounce_click_classifier_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	kdc_stream_if.sink      item_in,
	kdc_stream_if.source    result_out,
	kdc_stream_if.sink      cfg_wr
);

	kdc_pkg::cfg_regs_t regs;

	kdc_pkg::item_t   item_s1;
	logic             valid_s1;
	kdc_pkg::result_t result_s2;
	logic             valid_s2;
	logic             advance;

	logic                         level_q;
	logic [2:0]                   mode_q;
	logic [COUNT_WIDTH-1:0]       bounce_q;
	logic [COUNT_WIDTH-1:0]       window_q;
	logic [kdc_pkg::FLAG_W-1:0]   flags_q;

	logic                         level_d;
	logic [2:0]                   mode_d;
	logic [COUNT_WIDTH-1:0]       bounce_d;
	logic [COUNT_WIDTH-1:0]       window_d;
	logic [kdc_pkg::FLAG_W-1:0]   flags_d;
	kdc_pkg::result_t             result_d;

	// Configuration port, always ready
	assign cfg_wr.ready = 1'b1;

	kdc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_wr.valid),
		.wr_beat (cfg_wr.payload),
		.regs    (regs)
	);

	// Handshake: stage 1 moves on when the result register is free or drains
	assign advance       = valid_s1 && (!valid_s2 || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			item_s1 <= item_in.payload;
		end
	end

	kdc_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.item     (item_s1),
		.regs     (regs),
		.level_q  (level_q),
		.mode_q   (mode_q),
		.bounce_q (bounce_q),
		.window_q (window_q),
		.flags_q  (flags_q),
		.level_d  (level_d),
		.mode_d   (mode_d),
		.bounce_d (bounce_d),
		.window_d (window_d),
		.flags_d  (flags_d),
		.result   (result_d)
	);

	// Block state, committed when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= 1'b0;
			mode_q   <= kdc_pkg::MODE_WAIT;
			bounce_q <= '0;
			window_q <= '0;
			flags_q  <= '0;
		end else if (advance) begin
			level_q  <= level_d;
			mode_q   <= mode_d;
			bounce_q <= bounce_d;
			window_q <= window_d;
			flags_q  <= flags_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign result_out.valid   = valid_s2;
	assign result_out.payload = result_s2;

endmodule

### rtl/core/kdc_checker.sv
// Port-level checker for the click classifier core, with its bind.
`include "assert_macros.svh"

module kdc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input kdc_pkg::result_t out_payload,
	input logic             cfg_valid,
	input logic             cfg_ready
);

	// A stalled result beat holds
	`KDC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

	// A new result beat follows an accepted item beat
	`KDC_ASSERT_IMP(a_out_cause, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

	// With the result register empty, the input side never stalls
	`KDC_ASSERT_IMP(a_in_free, clk, arst_n, !out_valid, in_ready)

	// Config writes never stall
	`KDC_ASSERT_IMP(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind key_debounce_click_classifier_core kdc_checker u_kdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item_in.valid),
	.in_ready    (item_in.ready),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.out_payload (result_out.payload),
	.cfg_valid   (cfg_wr.valid),
	.cfg_ready   (cfg_wr.ready)
);
